// ----- hw/rtl/quaternion_to_euler_angles_assert.svh -----
// Assertion macros for the quaternion to Euler angle converter.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QTE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define QTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/qte_pkg.sv -----
// Shared constants, types and tables for the quaternion to Euler angle converter.
`default_nettype none
package qte_pkg;
    localparam int CORDIC_STAGES = 14;
    localparam int QW = 16;
    localparam int PW = 32;
    localparam int OPW = 34;
    localparam int CW = 38;
    localparam int AW = 28;
    localparam int SQW = 28;
    localparam int NW = 57;
    localparam int RW = 58;
    localparam int SQRT_STEPS = 29;
    localparam int CRW = 29;
    localparam int FW = 30;

    localparam logic signed [AW-1:0] PI_Q24 = 28'sd52707179;
    localparam logic signed [AW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [OPW-1:0] POLE_LIM = 34'sd134190884;
    localparam logic signed [OPW-1:0] ONE_Q28 = 34'sd268435456;
    localparam logic [NW-1:0] ONE_Q56 = 57'h100000000000000;

    localparam logic [1:0] POLE_NONE = 2'd0;
    localparam logic [1:0] POLE_POS = 2'd1;
    localparam logic [1:0] POLE_NEG = 2'd2;

    typedef logic [1:0] pole_t;

    typedef struct packed {
        pole_t                  pole;
        logic signed [QW-1:0]   qj;
        logic signed [QW-1:0]   qw;
        logic signed [OPW-1:0]  y1;
        logic signed [OPW-1:0]  x1;
        logic signed [OPW-1:0]  y3;
        logic signed [OPW-1:0]  x3;
        logic signed [OPW-1:0]  s;
    } side_t;

    function automatic logic signed [AW-1:0] atan_q24(input int idx);
        logic signed [AW-1:0] v;
        case (idx)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            8:  v = 28'sd65536;
            9:  v = 28'sd32768;
            10: v = 28'sd16384;
            11: v = 28'sd8192;
            12: v = 28'sd4096;
            13: v = 28'sd2048;
            14: v = 28'sd1024;
            15: v = 28'sd512;
            16: v = 28'sd256;
            17: v = 28'sd128;
            18: v = 28'sd64;
            19: v = 28'sd32;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/qte_products.sv -----
// Front end: quaternion products, pole test, CORDIC operands and sqrt radicand.
`default_nettype none
module qte_products (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [qte_pkg::QW-1:0]     quat_w,
    input  wire logic signed [qte_pkg::QW-1:0]     quat_i,
    input  wire logic signed [qte_pkg::QW-1:0]     quat_j,
    input  wire logic signed [qte_pkg::QW-1:0]     quat_k,
    output logic                                   out_valid,
    output logic [qte_pkg::NW-1:0]                 radicand,
    output qte_pkg::side_t                         side
);
    logic                              va_reg, vb_reg, vc_reg;
    logic signed [qte_pkg::PW-1:0]     ik_reg, wj_reg, iw_reg, jk_reg, kk_reg;
    logic signed [qte_pkg::PW-1:0]     ww_reg, ij_reg, kw_reg, jj_reg;
    logic signed [qte_pkg::QW-1:0]     qj_reg, qw_reg;
    qte_pkg::side_t                    sb_next, sb_reg, sc_reg;
    logic [qte_pkg::SQW-1:0]           abs_next, abs_reg;
    logic [qte_pkg::NW-1:0]            rad_next, rad_reg;
    logic signed [qte_pkg::OPW-1:0]    test, sabs;
    logic [2*qte_pkg::SQW-1:0]         sq;

    always_comb
    begin
        test = qte_pkg::OPW'(ik_reg) - qte_pkg::OPW'(wj_reg);
        sb_next.qj = qj_reg;
        sb_next.qw = qw_reg;
        sb_next.s = test <<< 1;
        sb_next.y1 = (qte_pkg::OPW'(iw_reg) + qte_pkg::OPW'(jk_reg)) <<< 1;
        sb_next.x1 = qte_pkg::ONE_Q28 - ((qte_pkg::OPW'(kk_reg) + qte_pkg::OPW'(ww_reg)) <<< 1);
        sb_next.y3 = (qte_pkg::OPW'(ij_reg) - qte_pkg::OPW'(kw_reg)) <<< 1;
        sb_next.x3 = qte_pkg::ONE_Q28 - ((qte_pkg::OPW'(jj_reg) + qte_pkg::OPW'(kk_reg)) <<< 1);
        if (test > qte_pkg::POLE_LIM)
        begin
            sb_next.pole = qte_pkg::POLE_POS;
        end
        else if (test < -qte_pkg::POLE_LIM)
        begin
            sb_next.pole = qte_pkg::POLE_NEG;
        end
        else
        begin
            sb_next.pole = qte_pkg::POLE_NONE;
        end
        sabs = (sb_next.s < 0) ? -sb_next.s : sb_next.s;
        abs_next = sabs[qte_pkg::SQW-1:0];
        sq = abs_reg * abs_reg;
        rad_next = qte_pkg::ONE_Q56 - qte_pkg::NW'(sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ik_reg <= quat_i * quat_k;
            wj_reg <= quat_w * quat_j;
            iw_reg <= quat_i * quat_w;
            jk_reg <= quat_j * quat_k;
            kk_reg <= quat_k * quat_k;
            ww_reg <= quat_w * quat_w;
            ij_reg <= quat_i * quat_j;
            kw_reg <= quat_k * quat_w;
            jj_reg <= quat_j * quat_j;
            qj_reg <= quat_j;
            qw_reg <= quat_w;
            sb_reg <= sb_next;
            abs_reg <= abs_next;
            sc_reg <= sb_reg;
            rad_reg <= rad_next;
        end
    end

    assign out_valid = vc_reg;
    assign radicand = rad_reg;
    assign side = sc_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/qte_isqrt.sv -----
// Pipelined floor integer square root, one result bit per stage.
`default_nettype none
module qte_isqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [qte_pkg::NW-1:0]        radicand,
    input  qte_pkg::side_t                     in_side,
    output logic                               out_valid,
    output logic [qte_pkg::CRW-1:0]            root,
    output qte_pkg::side_t                     out_side
);
    localparam int N = qte_pkg::SQRT_STEPS;

    logic                       valid_reg [0:N];
    logic [qte_pkg::NW-1:0]     n_reg     [0:N];
    logic [qte_pkg::RW-1:0]     r_reg     [0:N];
    qte_pkg::side_t             side_reg  [0:N];
    logic [qte_pkg::NW-1:0]     n_next    [1:N];
    logic [qte_pkg::RW-1:0]     r_next    [1:N];
    logic [qte_pkg::RW-1:0]     trial     [1:N];

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            trial[k+1] = r_reg[k] + (qte_pkg::RW'(1) << (2 * (N - 1 - k)));
            if (qte_pkg::RW'(n_reg[k]) >= trial[k+1])
            begin
                n_next[k+1] = qte_pkg::NW'(qte_pkg::RW'(n_reg[k]) - trial[k+1]);
                r_next[k+1] = (r_reg[k] >> 1) + (qte_pkg::RW'(1) << (2 * (N - 1 - k)));
            end
            else
            begin
                n_next[k+1] = n_reg[k];
                r_next[k+1] = r_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= N; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= radicand;
            r_reg[0] <= '0;
            side_reg[0] <= in_side;
            for (int k = 1; k <= N; k++)
            begin
                n_reg[k] <= n_next[k];
                r_reg[k] <= r_next[k];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign root = r_reg[N][qte_pkg::CRW-1:0];
    assign out_side = side_reg[N];
endmodule
`default_nettype wire

// ----- hw/rtl/qte_cordic.sv -----
// Pipelined vectoring CORDIC giving atan2(y, x) in Q24 radians.
`default_nettype none
module qte_cordic (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [qte_pkg::OPW-1:0] y,
    input  wire logic signed [qte_pkg::OPW-1:0] x,
    input  qte_pkg::pole_t                     in_tag,
    output logic                               out_valid,
    output logic signed [qte_pkg::AW-1:0]      angle,
    output qte_pkg::pole_t                     out_tag
);
    localparam int N = qte_pkg::CORDIC_STAGES;

    logic                           valid_reg [0:N];
    logic                           zero_reg  [0:N];
    qte_pkg::pole_t                 tag_reg   [0:N];
    logic signed [qte_pkg::CW-1:0]  x_reg     [0:N];
    logic signed [qte_pkg::CW-1:0]  y_reg     [0:N];
    logic signed [qte_pkg::AW-1:0]  acc_reg   [0:N];
    logic signed [qte_pkg::CW-1:0]  x_next    [0:N];
    logic signed [qte_pkg::CW-1:0]  y_next    [0:N];
    logic signed [qte_pkg::AW-1:0]  acc_next  [0:N];
    logic signed [qte_pkg::CW-1:0]  xe, ye, dx, dy;
    logic signed [qte_pkg::AW-1:0]  fin;

    always_comb
    begin
        xe = qte_pkg::CW'(x);
        ye = qte_pkg::CW'(y);
        if (x < 0)
        begin
            x_next[0] = -xe;
            y_next[0] = -ye;
            acc_next[0] = (y >= 0) ? qte_pkg::PI_Q24 : -qte_pkg::PI_Q24;
        end
        else
        begin
            x_next[0] = xe;
            y_next[0] = ye;
            acc_next[0] = '0;
        end
        dx = '0;
        dy = '0;
        for (int g = 0; g < N; g++)
        begin
            dx = x_reg[g] >>> g;
            dy = y_reg[g] >>> g;
            if (y_reg[g] > 0)
            begin
                x_next[g+1] = x_reg[g] + dy;
                y_next[g+1] = y_reg[g] - dx;
                acc_next[g+1] = acc_reg[g] + qte_pkg::atan_q24(g);
            end
            else
            begin
                x_next[g+1] = x_reg[g] - dy;
                y_next[g+1] = y_reg[g] + dx;
                acc_next[g+1] = acc_reg[g] - qte_pkg::atan_q24(g);
            end
        end
        if (zero_reg[N])
        begin
            fin = '0;
        end
        else if (acc_reg[N] > qte_pkg::PI_Q24)
        begin
            fin = qte_pkg::PI_Q24;
        end
        else if (acc_reg[N] < -qte_pkg::PI_Q24)
        begin
            fin = -qte_pkg::PI_Q24;
        end
        else
        begin
            fin = acc_reg[N];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g <= N; g++)
            begin
                valid_reg[g] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int g = 1; g <= N; g++)
            begin
                valid_reg[g] <= valid_reg[g-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x == 0) && (y == 0);
            tag_reg[0] <= in_tag;
            for (int g = 0; g <= N; g++)
            begin
                x_reg[g] <= x_next[g];
                y_reg[g] <= y_next[g];
                acc_reg[g] <= acc_next[g];
            end
            for (int g = 1; g <= N; g++)
            begin
                zero_reg[g] <= zero_reg[g-1];
                tag_reg[g] <= tag_reg[g-1];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign angle = fin;
    assign out_tag = tag_reg[N];
endmodule
`default_nettype wire

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// Throughput: one request per cycle while the output skid register is empty.
// Stages: products 3, sqrt 1+29, CORDIC 1+14, output 1.
// The pipeline freezes only while the output skid register holds a request.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
// Top level: quaternion to Euler angles with pole handling, output register and skid.
`default_nettype none
`include "quaternion_to_euler_angles_assert.svh"
module quaternion_to_euler_angles (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [qte_pkg::QW-1:0]  quat_w,
    input  wire logic signed [qte_pkg::QW-1:0]  quat_i,
    input  wire logic signed [qte_pkg::QW-1:0]  quat_j,
    input  wire logic signed [qte_pkg::QW-1:0]  quat_k,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [15:0]                  first_angle,
    output logic signed [13:0]                  second_angle,
    output logic signed [14:0]                  third_angle,
    output logic [1:0]                          pole_case
);
    logic                               en;
    logic                               p_valid, q_valid, c_valid;
    logic                               c2_valid, c3_valid;
    logic [qte_pkg::NW-1:0]             radicand;
    qte_pkg::side_t                     p_side, q_side;
    logic [qte_pkg::CRW-1:0]            root;
    logic signed [qte_pkg::OPW-1:0]     c1_y, c1_x, c2_x;
    logic signed [qte_pkg::AW-1:0]      a1, a2, a3;
    qte_pkg::pole_t                     c_pole, c2_pole, c3_pole;
    logic signed [qte_pkg::FW-1:0]      f_q24, s_q24, t_q24;
    logic signed [qte_pkg::FW-1:0]      f_rnd, s_rnd, t_rnd;
    logic signed [15:0]                 f_next, first_reg, first_skid_reg;
    logic signed [13:0]                 s_next, second_reg, second_skid_reg;
    logic signed [14:0]                 t_next, third_reg, third_skid_reg;
    logic [1:0]                         pole_reg, pole_skid_reg;
    logic                               out_valid_reg, skid_valid_reg;
    logic                               push, take;
    logic                               pole_out, pole_known, lanes_same;

    assign en = !skid_valid_reg;

    qte_products u_products (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .quat_w    (quat_w),
        .quat_i    (quat_i),
        .quat_j    (quat_j),
        .quat_k    (quat_k),
        .out_valid (p_valid),
        .radicand  (radicand),
        .side      (p_side)
    );

    qte_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid),
        .radicand  (radicand),
        .in_side   (p_side),
        .out_valid (q_valid),
        .root      (root),
        .out_side  (q_side)
    );

    always_comb
    begin
        if (q_side.pole != qte_pkg::POLE_NONE)
        begin
            c1_y = qte_pkg::OPW'(q_side.qj);
            c1_x = qte_pkg::OPW'(q_side.qw);
        end
        else
        begin
            c1_y = q_side.y1;
            c1_x = q_side.x1;
        end
        c2_x = signed'(qte_pkg::OPW'(root));
    end

    qte_cordic u_cordic_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .y         (c1_y),
        .x         (c1_x),
        .in_tag    (q_side.pole),
        .out_valid (c_valid),
        .angle     (a1),
        .out_tag   (c_pole)
    );

    qte_cordic u_cordic_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .y         (q_side.s),
        .x         (c2_x),
        .in_tag    (q_side.pole),
        .out_valid (c2_valid),
        .angle     (a2),
        .out_tag   (c2_pole)
    );

    qte_cordic u_cordic_third (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .y         (q_side.y3),
        .x         (q_side.x3),
        .in_tag    (q_side.pole),
        .out_valid (c3_valid),
        .angle     (a3),
        .out_tag   (c3_pole)
    );

    always_comb
    begin
        case (c_pole)
            qte_pkg::POLE_POS:
            begin
                f_q24 = qte_pkg::FW'(a1) <<< 1;
                s_q24 = qte_pkg::FW'(qte_pkg::HALF_PI_Q24);
                t_q24 = '0;
            end
            qte_pkg::POLE_NEG:
            begin
                f_q24 = -(qte_pkg::FW'(a1) <<< 1);
                s_q24 = -qte_pkg::FW'(qte_pkg::HALF_PI_Q24);
                t_q24 = '0;
            end
            default:
            begin
                f_q24 = qte_pkg::FW'(a1);
                if (a2 > qte_pkg::HALF_PI_Q24)
                begin
                    s_q24 = qte_pkg::FW'(qte_pkg::HALF_PI_Q24);
                end
                else if (a2 < -qte_pkg::HALF_PI_Q24)
                begin
                    s_q24 = -qte_pkg::FW'(qte_pkg::HALF_PI_Q24);
                end
                else
                begin
                    s_q24 = qte_pkg::FW'(a2);
                end
                t_q24 = qte_pkg::FW'(a3);
            end
        endcase
        f_rnd = (f_q24 + qte_pkg::FW'(2048)) >>> 12;
        s_rnd = (s_q24 + qte_pkg::FW'(2048)) >>> 12;
        t_rnd = (t_q24 + qte_pkg::FW'(2048)) >>> 12;
        f_next = f_rnd[15:0];
        s_next = s_rnd[13:0];
        t_next = t_rnd[14:0];
    end

    assign push = en && c_valid;
    assign take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                first_reg <= first_skid_reg;
                second_reg <= second_skid_reg;
                third_reg <= third_skid_reg;
                pole_reg <= pole_skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                first_skid_reg <= f_next;
                second_skid_reg <= s_next;
                third_skid_reg <= t_next;
                pole_skid_reg <= c_pole;
            end
            else
            begin
                first_reg <= f_next;
                second_reg <= s_next;
                third_reg <= t_next;
                pole_reg <= c_pole;
            end
        end
    end

    assign in_stall = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign first_angle = first_reg;
    assign second_angle = second_reg;
    assign third_angle = third_reg;
    assign pole_case = pole_reg;

    assign pole_out = out_valid_reg && (pole_reg != qte_pkg::POLE_NONE);
    assign pole_known = (pole_reg == qte_pkg::POLE_NONE) || (pole_reg == qte_pkg::POLE_POS)
                        || (pole_reg == qte_pkg::POLE_NEG);
    assign lanes_same = (c2_pole == c_pole) && (c3_pole == c_pole);

    `QTE_ASSERT_IMPL(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `QTE_ASSERT_IMPL(a_pole_code, clk, rst_n, out_valid_reg, pole_known)
    `QTE_ASSERT_IMPL(a_pole_third_zero, clk, rst_n, pole_out, third_reg == 15'sd0)
    `QTE_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_reg && !out_stall, !skid_valid_reg)
    `QTE_ASSERT_IMPL(a_lanes_valid, clk, rst_n, 1'b1, (c2_valid == c_valid) && (c3_valid == c_valid))
    `QTE_ASSERT_IMPL(a_lanes_tag, clk, rst_n, c_valid, lanes_same)
endmodule
`default_nettype wire

// ----- verif/quaternion_to_euler_angles_test.sv -----
// Self-checking testbench for the quaternion to Euler angle converter.
`default_nettype none
module quaternion_to_euler_angles_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 49;
    localparam int N_RANDOM = 1300;
    localparam longint Q24_PI = 64'sd52707179;
    localparam longint Q24_HALF_PI = 64'sd26353589;
    localparam longint Q28_ONE = 64'sd268435456;
    localparam longint POLE_EDGE = 64'sd134217728 - 64'sd26844;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] i;
        logic signed [15:0] j;
        logic signed [15:0] k;
    } quat_t;

    typedef struct {
        logic signed [15:0] first;
        logic signed [13:0] second;
        logic signed [14:0] third;
        qte_pkg::pole_t     pole;
    } euler_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] quat_w = '0;
    logic signed [15:0] quat_i = '0;
    logic signed [15:0] quat_j = '0;
    logic signed [15:0] quat_k = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] first_angle;
    logic signed [13:0] second_angle;
    logic signed [14:0] third_angle;
    logic [1:0] pole_case;

    quat_t pending_quats[$];
    euler_t expected_angles[$];
    int errors = 0;
    int n_checked = 0;
    int n_poles = 0;
    bit in_accepted = 1'b0;
    bit hold_off = 1'b0;
    int burst_left = 0;
    int gap_left = 0;

    quaternion_to_euler_angles dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            acc = (y >= 0) ? Q24_PI : -Q24_PI;
            x = -x;
            y = -y;
        end
        for (int s = 0; s < qte_pkg::CORDIC_STAGES && s < 20; s++)
        begin
            dx = floor_shift(x, s);
            dy = floor_shift(y, s);
            if (y > 0)
            begin
                x += dy;
                y -= dx;
                acc += longint'(qte_pkg::atan_q24(s));
            end
            else
            begin
                x -= dy;
                y += dx;
                acc -= longint'(qte_pkg::atan_q24(s));
            end
        end
        if (acc > Q24_PI)
            acc = Q24_PI;
        if (acc < -Q24_PI)
            acc = -Q24_PI;
        return acc;
    endfunction

    function automatic longint round_q12(longint a);
        return floor_shift(a + 2048, 12);
    endfunction

    function automatic euler_t euler_of(quat_t q);
        longint w;
        longint i;
        longint j;
        longint k;
        longint t;
        longint f;
        longint sc;
        longint th;
        longint s;
        longint c;
        longint unsigned s2;
        euler_t e;
        w = q.w;
        i = q.i;
        j = q.j;
        k = q.k;
        t = i * k - w * j;
        if (t > POLE_EDGE)
        begin
            f = 2 * vector_angle(j, w);
            sc = Q24_HALF_PI;
            th = 0;
            e.pole = qte_pkg::POLE_POS;
        end
        else if (t < -POLE_EDGE)
        begin
            f = -2 * vector_angle(j, w);
            sc = -Q24_HALF_PI;
            th = 0;
            e.pole = qte_pkg::POLE_NEG;
        end
        else
        begin
            s = 2 * t;
            s2 = longint'(s < 0 ? -s : s);
            s2 = s2 * s2;
            c = int_sqrt((64'd1 << 56) - s2);
            f = vector_angle(2 * (i * w + j * k), Q28_ONE - 2 * (k * k + w * w));
            sc = vector_angle(s, c);
            if (sc > Q24_HALF_PI)
                sc = Q24_HALF_PI;
            if (sc < -Q24_HALF_PI)
                sc = -Q24_HALF_PI;
            th = vector_angle(2 * (i * j - k * w), Q28_ONE - 2 * (j * j + k * k));
            e.pole = qte_pkg::POLE_NONE;
        end
        e.first = 16'(round_q12(f));
        e.second = 14'(round_q12(sc));
        e.third = 15'(round_q12(th));
        return e;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    endtask

    task automatic add_quat(int w, int i, int j, int k);
        quat_t q;
        q.w = 16'(w);
        q.i = 16'(i);
        q.j = 16'(j);
        q.k = 16'(k);
        pending_quats.push_back(q);
    endtask

    function automatic int rand_comp();
        return $urandom_range(32768) - 16384;
    endfunction

    // driver: bursts and gaps; valid held until accepted
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_accepted)
                ;
            else if (pending_quats.size() == 0)
                in_valid <= 1'b0;
            else if (burst_left == 0 && gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(40, 1);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end
                burst_left--;
                in_valid <= 1'b1;
                quat_w <= pending_quats[0].w;
                quat_i <= pending_quats[0].i;
                quat_j <= pending_quats[0].j;
                quat_k <= pending_quats[0].k;
            end
            in_accepted = 1'b0;
        end
    end

    // prediction recorded on accept
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            quat_t q;
            q.w = quat_w;
            q.i = quat_i;
            q.j = quat_j;
            q.k = quat_k;
            expected_angles.push_back(euler_of(q));
            void'(pending_quats.pop_front());
            in_accepted = 1'b1;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            case ($urandom_range(3))
                0: out_stall <= 1'b1;
                1: out_stall <= ($urandom_range(7) == 0);
                default: out_stall <= 1'b0;
            endcase
    end

    // long receiver hold-off
    initial
    begin
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_angles.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                euler_t e;
                e = expected_angles.pop_front();
                if (first_angle !== e.first)
                    report_mismatch("first_angle", first_angle, e.first);
                if (second_angle !== e.second)
                    report_mismatch("second_angle", second_angle, e.second);
                if (third_angle !== e.third)
                    report_mismatch("third_angle", third_angle, e.third);
                if (pole_case !== e.pole)
                    report_mismatch("pole_case", pole_case, e.pole);
                if (e.pole != qte_pkg::POLE_NONE)
                    n_poles++;
            end
            n_checked++;
        end
    end

    initial
    begin
        int a;
        int b;
        int sg;
        // directed: extremes, identity, both poles, just inside and outside the margin
        add_quat(16384, 0, 0, 0);
        add_quat(-16384, 0, 0, 0);
        add_quat(0, 0, 0, 0);
        add_quat(16384, 16384, 16384, 16384);
        add_quat(-16384, -16384, -16384, -16384);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(32767, -32768, 32767, -32768);
        add_quat(11585, 0, -11585, 0);
        add_quat(11585, 0, 11585, 0);
        add_quat(0, 11585, 0, 11585);
        add_quat(0, 11585, 0, -11585);
        add_quat(8192, 8192, -8192, 8192);
        add_quat(8192, -8192, 8192, -8192);
        add_quat(11584, 0, -11584, 0);
        add_quat(11580, 0, -11580, 0);
        add_quat(11590, 0, 11590, 0);
        add_quat(0, 16384, 0, 0);
        add_quat(0, 0, 16384, 0);
        add_quat(0, 0, 0, 16384);
        add_quat(0, -16384, 0, 0);
        add_quat(-1, -1, -1, -1);
        add_quat(1, 1, 1, 1);
        for (int n = 0; n < N_RANDOM; n++)
            case ($urandom_range(5))
                0:
                begin
                    a = rand_comp();
                    sg = $urandom_range(1) ? 1 : -1;
                    b = a + $urandom_range(8) - 4;
                    add_quat(a, b, -sg * a + $urandom_range(4) - 2, sg * b);
                end
                1: add_quat($urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), $urandom_range(65535));
                default: add_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            endcase
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending_quats.size() != 0)
            @(posedge clk);
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        $display("checked %0d conversions, %0d at a pole, with random input gaps", n_checked,
                 n_poles);
        $display("and output stalls including one long hold-off that backed up the pipeline");
        if (errors == 0)
            $display("** quaternion_to_euler_angles: PASSED **");
        else
            $display("** quaternion_to_euler_angles: FAILED **");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout");
        $display("** quaternion_to_euler_angles: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
